FILE: src/psar_pkg.sv
// ----------------------------------------------------------------------------
// psar_pkg
// Types and constants shared by the scroll and VRAM address unit.
// ----------------------------------------------------------------------------
package psar_pkg;

   typedef enum logic [3:0] {
      ACT_CTRL_WRITE   = 4'd0,
      ACT_SCROLL_WRITE = 4'd1,
      ACT_ADDR_WRITE   = 4'd2,
      ACT_DATA_ACCESS  = 4'd3,
      ACT_STATUS_READ  = 4'd4,
      ACT_INC_X        = 4'd5,
      ACT_INC_Y        = 4'd6,
      ACT_HCOPY        = 4'd7,
      ACT_VCOPY        = 4'd8
   } psar_action_type;

   localparam int unsigned AddrWidth   = 15;
   localparam int unsigned AccessWidth = 14;

   localparam logic [AddrWidth-1:0] HCopyMask = 15'h041F;
   localparam logic [AddrWidth-1:0] VCopyMask = 15'h7BE0;
   localparam logic [4:0]           RowWrap   = 5'd29;
   localparam logic [4:0]           RowLast   = 5'd31;
   localparam logic [4:0]           ColLast   = 5'd31;
   localparam logic [2:0]           FineLast  = 3'd7;

   typedef struct packed {
      logic [AddrWidth-1:0] vram;
      logic [AddrWidth-1:0] temp;
      logic [2:0]           fine_x;
      logic                 toggle;
      logic                 inc_32;
   } psar_state_type;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] data_byte;
      logic       rendering_enabled;
      logic       in_render_line;
   } psar_item_type;

   typedef struct packed {
      logic [AddrWidth-1:0]   vram_addr;
      logic [AddrWidth-1:0]   temp_addr;
      logic [2:0]             fine_x;
      logic                   write_toggle;
      logic [AccessWidth-1:0] access_addr;
   } psar_result_type;

endpackage

FILE: src/psar_req_if.sv
// ----------------------------------------------------------------------------
// psar_req_if
// Event channel into the scroll and VRAM address unit.
// ----------------------------------------------------------------------------
interface psar_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] action;
   logic [7:0] data_byte;
   logic       rendering_enabled;
   logic       in_render_line;

   modport source (
      output valid, action, data_byte, rendering_enabled, in_render_line,
      input  ready
   );
   modport sink (
      input  valid, action, data_byte, rendering_enabled, in_render_line,
      output ready
   );
endinterface

FILE: src/psar_rsp_if.sv
// ----------------------------------------------------------------------------
// psar_rsp_if
// Result channel out of the scroll and VRAM address unit.
// ----------------------------------------------------------------------------
interface psar_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] vram_addr;
   logic [14:0] temp_addr;
   logic [2:0]  fine_x;
   logic        write_toggle;
   logic [13:0] access_addr;

   modport source (
      output valid, vram_addr, temp_addr, fine_x, write_toggle, access_addr,
      input  ready
   );
   modport sink (
      input  valid, vram_addr, temp_addr, fine_x, write_toggle, access_addr,
      output ready
   );
endinterface

FILE: src/psar_step.sv
// ----------------------------------------------------------------------------
// psar_step
// Next-state logic for v, t, fine X, the write toggle and the increment mode for one event.
// ----------------------------------------------------------------------------
module psar_step
   import psar_pkg::*;
(
   input  psar_state_type         state,
   input  psar_item_type          item,
   output psar_state_type         next_state,
   output logic [AccessWidth-1:0] access_addr
);

   function automatic logic [AddrWidth-1:0] step_x(input logic [AddrWidth-1:0] v);
      logic [AddrWidth-1:0] r;
      r = v;
      if (v[4:0] == ColLast) begin
         r[4:0] = 5'd0;
         r[10]  = ~v[10];
      end else begin
         r[4:0] = v[4:0] + 5'd1;
      end
      return r;
   endfunction

   function automatic logic [AddrWidth-1:0] step_y(input logic [AddrWidth-1:0] v);
      logic [AddrWidth-1:0] r;
      r = v;
      if (v[14:12] != FineLast) begin
         r[14:12] = v[14:12] + 3'd1;
      end else begin
         r[14:12] = 3'd0;
         if (v[9:5] == RowWrap) begin
            r[9:5] = 5'd0;
            r[11]  = ~v[11];
         end else if (v[9:5] == RowLast) begin
            r[9:5] = 5'd0;
         end else begin
            r[9:5] = v[9:5] + 5'd1;
         end
      end
      return r;
   endfunction

   logic [AddrWidth-1:0] step_amount;

   assign step_amount = state.inc_32 ? AddrWidth'(32) : AddrWidth'(1);

   always_comb begin
      next_state  = state;
      access_addr = '0;
      unique case (item.action)
         ACT_CTRL_WRITE: begin
            next_state.temp[11:10] = item.data_byte[1:0];
            next_state.inc_32      = item.data_byte[2];
         end
         ACT_SCROLL_WRITE: begin
            if (state.toggle) begin
               next_state.temp[14:12] = item.data_byte[2:0];
               next_state.temp[9:5]   = item.data_byte[7:3];
            end else begin
               next_state.temp[4:0] = item.data_byte[7:3];
               next_state.fine_x    = item.data_byte[2:0];
            end
            next_state.toggle = ~state.toggle;
         end
         ACT_ADDR_WRITE: begin
            if (state.toggle) begin
               next_state.temp[7:0] = item.data_byte;
               next_state.vram      = {state.temp[14:8], item.data_byte};
            end else begin
               next_state.temp[13:8] = item.data_byte[5:0];
               next_state.temp[14]   = 1'b0;
            end
            next_state.toggle = ~state.toggle;
         end
         ACT_DATA_ACCESS: begin
            access_addr = state.vram[AccessWidth-1:0];
            if (item.rendering_enabled && item.in_render_line) begin
               next_state.vram = step_y(step_x(state.vram));
            end else begin
               next_state.vram = state.vram + step_amount;
            end
         end
         ACT_STATUS_READ: begin
            next_state.toggle = 1'b0;
         end
         ACT_INC_X: begin
            if (item.rendering_enabled) next_state.vram = step_x(state.vram);
         end
         ACT_INC_Y: begin
            if (item.rendering_enabled) next_state.vram = step_y(state.vram);
         end
         ACT_HCOPY: begin
            if (item.rendering_enabled) begin
               next_state.vram = (state.vram & ~HCopyMask) | (state.temp & HCopyMask);
            end
         end
         ACT_VCOPY: begin
            if (item.rendering_enabled) begin
               next_state.vram = (state.vram & ~VCopyMask) | (state.temp & VCopyMask);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: src/ppu_scroll_address_registers_unit.sv
// ----------------------------------------------------------------------------
// ppu_scroll_address_registers_unit
// Scroll and VRAM address registers (v, t, fine X, write toggle).
// ----------------------------------------------------------------------------
// Takes one event per clock while the skid register is empty. Each accepted
// event updates v, t, fine X and the write toggle in the same cycle; its
// result word goes to the result register, or to the skid register when
// the result register is still full. The two-entry buffer lets the unit
// take one more event while the response side stalls; the request side
// stalls only while both entries are full. No clearing pass after reset.
module ppu_scroll_address_registers_unit
   import psar_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   psar_req_if.sink   req_chan,
   psar_rsp_if.source rsp_chan
);

   psar_state_type  state_ff, state_in;
   psar_item_type   item;
   psar_result_type result;
   psar_result_type head_ff, head_in, skid_ff, skid_in;
   logic            head_valid_ff, head_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   logic [AccessWidth-1:0] access_addr;
   logic            accept;
   logic            pop;

   assign item.action            = req_chan.action;
   assign item.data_byte         = req_chan.data_byte;
   assign item.rendering_enabled = req_chan.rendering_enabled;
   assign item.in_render_line    = req_chan.in_render_line;

   psar_step u_step (
      .state       (state_ff),
      .item        (item),
      .next_state  (state_in),
      .access_addr (access_addr)
   );

   assign result.vram_addr    = state_in.vram;
   assign result.temp_addr    = state_in.temp;
   assign result.fine_x       = state_in.fine_x;
   assign result.write_toggle = state_in.toggle;
   assign result.access_addr  = access_addr;

   assign req_chan.ready = ~skid_valid_ff;
   assign accept         = req_chan.valid & ~skid_valid_ff;
   assign pop            = head_valid_ff & rsp_chan.ready;

   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!head_valid_ff || pop) begin
            head_in       = result;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) state_ff <= state_in;
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = head_valid_ff;
   assign rsp_chan.vram_addr    = head_ff.vram_addr;
   assign rsp_chan.temp_addr    = head_ff.temp_addr;
   assign rsp_chan.fine_x       = head_ff.fine_x;
   assign rsp_chan.write_toggle = head_ff.write_toggle;
   assign rsp_chan.access_addr  = head_ff.access_addr;

`ifndef ASSERT_OFF
   a_skid_implies_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry held without a result entry");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> head_valid_ff)
      else $error("accepted event produced no result");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(state_ff))
      else $error("address state changed without an event");

   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff && !rsp_chan.ready |=> head_valid_ff && $stable(head_ff))
      else $error("stalled result lost or changed");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      accept && !head_valid_ff |=> head_ff.vram_addr == state_ff.vram
                                 && head_ff.temp_addr == state_ff.temp)
      else $error("result does not match updated state");
`endif

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scroll and VRAM address unit.
// ----------------------------------------------------------------------------
// A driver replays a queue of register and render-timing events with random
// gaps. A bit-accurate predictor of v, t, fine X, the write toggle and the
// increment mode builds one expected word per accepted event. A monitor checks
// every response word against it, field by field. The response side stalls at
// random and once holds off long enough to back the unit up into its input.
// ----------------------------------------------------------------------------
module tb;
   import psar_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int EventTarget   = 1600;
   localparam int WatchdogLimit = 1000;
   localparam int HoldStart     = 1500;
   localparam int HoldCycles    = 250;
   localparam int DrainCycles   = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psar_req_if req_chan ();
   psar_rsp_if rsp_chan ();

   ppu_scroll_address_registers_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   psar_item_type   pending_events[$];
   psar_result_type expected_regs[$];
   psar_state_type  scroll_state;

   int events_sent    = 0;
   int events_taken   = 0;
   int words_checked  = 0;
   int mismatches     = 0;
   int idle_cycles    = 0;
   int send_gap       = 0;
   int recv_gap       = 0;
   int recv_cycles    = 0;
   int hold_left      = 0;
   int action_hits[16];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [14:0] coarse_x_step(input logic [14:0] a);
      logic [14:0] r;
      r = a;
      if (a[4:0] == ColLast) begin
         r[4:0] = 5'd0;
         r[10]  = ~a[10];
      end else begin
         r[4:0] = a[4:0] + 5'd1;
      end
      return r;
   endfunction

   function automatic logic [14:0] fine_y_step(input logic [14:0] a);
      logic [14:0] r;
      r = a;
      if (a[14:12] != FineLast) begin
         r[14:12] = a[14:12] + 3'd1;
      end else begin
         r[14:12] = 3'd0;
         if (a[9:5] == RowWrap) begin
            r[9:5] = 5'd0;
            r[11]  = ~a[11];
         end else if (a[9:5] == RowLast) begin
            r[9:5] = 5'd0;
         end else begin
            r[9:5] = a[9:5] + 5'd1;
         end
      end
      return r;
   endfunction

   function automatic psar_result_type predict_scroll(input psar_item_type ev);
      psar_result_type res;
      logic [7:0]      d;
      logic            rend;
      d    = ev.data_byte;
      rend = ev.rendering_enabled;
      res  = '0;
      case (ev.action)
         ACT_CTRL_WRITE: begin
            scroll_state.temp[11:10] = d[1:0];
            scroll_state.inc_32      = d[2];
         end
         ACT_SCROLL_WRITE: begin
            if (scroll_state.toggle) begin
               scroll_state.temp[14:12] = d[2:0];
               scroll_state.temp[9:5]   = d[7:3];
            end else begin
               scroll_state.temp[4:0] = d[7:3];
               scroll_state.fine_x    = d[2:0];
            end
            scroll_state.toggle = ~scroll_state.toggle;
         end
         ACT_ADDR_WRITE: begin
            if (scroll_state.toggle) begin
               scroll_state.temp[7:0] = d;
               scroll_state.vram      = scroll_state.temp;
            end else begin
               scroll_state.temp[13:8] = d[5:0];
               scroll_state.temp[14]   = 1'b0;
            end
            scroll_state.toggle = ~scroll_state.toggle;
         end
         ACT_DATA_ACCESS: begin
            res.access_addr = scroll_state.vram[13:0];
            if (rend && ev.in_render_line)
               scroll_state.vram = fine_y_step(coarse_x_step(scroll_state.vram));
            else
               scroll_state.vram = scroll_state.vram + (scroll_state.inc_32 ? 15'd32 : 15'd1);
         end
         ACT_STATUS_READ: scroll_state.toggle = 1'b0;
         ACT_INC_X: if (rend) scroll_state.vram = coarse_x_step(scroll_state.vram);
         ACT_INC_Y: if (rend) scroll_state.vram = fine_y_step(scroll_state.vram);
         ACT_HCOPY: begin
            if (rend)
               scroll_state.vram = (scroll_state.vram & ~HCopyMask)
                                 | (scroll_state.temp & HCopyMask);
         end
         ACT_VCOPY: begin
            if (rend)
               scroll_state.vram = (scroll_state.vram & ~VCopyMask)
                                 | (scroll_state.temp & VCopyMask);
         end
         default: ;
      endcase
      res.vram_addr    = scroll_state.vram;
      res.temp_addr    = scroll_state.temp;
      res.fine_x       = scroll_state.fine_x;
      res.write_toggle = scroll_state.toggle;
      return res;
   endfunction

   task automatic queue_event(input logic [3:0] act, input logic [7:0] d,
                              input logic rend, input logic line);
      psar_item_type ev;
      ev.action            = act;
      ev.data_byte         = d;
      ev.rendering_enabled = rend;
      ev.in_render_line    = line;
      pending_events.push_back(ev);
   endtask

   function automatic logic rand_rend();
      return $urandom_range(0, 3) != 0;
   endfunction

   // driver
   always @(posedge clock) begin
      psar_item_type ev;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (send_gap > 0) begin
            req_chan.valid <= 1'b0;
            send_gap = send_gap - 1;
         end else if (pending_events.size() > 0) begin
            ev = pending_events.pop_front();
            req_chan.valid             <= 1'b1;
            req_chan.action            <= ev.action;
            req_chan.data_byte         <= ev.data_byte;
            req_chan.rendering_enabled <= ev.rendering_enabled;
            req_chan.in_render_line    <= ev.in_render_line;
            events_sent = events_sent + 1;
            send_gap = ((events_sent / 128) % 3 == 0) ? 0 : $urandom_range(0, 9);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold to back up the unit
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         recv_cycles = recv_cycles + 1;
         if (recv_cycles == HoldStart)
            hold_left = HoldCycles;
         if (rsp_chan.valid && rsp_chan.ready)
            recv_gap = ((words_checked / 100) % 3 == 1) ? 0 : $urandom_range(0, 9);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      psar_item_type   ev;
      psar_result_type got;
      psar_result_type want;
      if (reset) begin
         scroll_state = '0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.vram_addr    = rsp_chan.vram_addr;
            got.temp_addr    = rsp_chan.temp_addr;
            got.fine_x       = rsp_chan.fine_x;
            got.write_toggle = rsp_chan.write_toggle;
            got.access_addr  = rsp_chan.access_addr;
            if (expected_regs.size() == 0) begin
               $display("%0t unexpected word: vram %h temp %h", $time,
                        got.vram_addr, got.temp_addr);
               mismatches = mismatches + 1;
            end else begin
               want = expected_regs.pop_front();
               if (got.vram_addr !== want.vram_addr) begin
                  $display("%0t vram_addr expected %h actual %h", $time,
                           want.vram_addr, got.vram_addr);
                  mismatches = mismatches + 1;
               end
               if (got.temp_addr !== want.temp_addr) begin
                  $display("%0t temp_addr expected %h actual %h", $time,
                           want.temp_addr, got.temp_addr);
                  mismatches = mismatches + 1;
               end
               if (got.fine_x !== want.fine_x) begin
                  $display("%0t fine_x expected %h actual %h", $time,
                           want.fine_x, got.fine_x);
                  mismatches = mismatches + 1;
               end
               if (got.write_toggle !== want.write_toggle) begin
                  $display("%0t write_toggle expected %b actual %b", $time,
                           want.write_toggle, got.write_toggle);
                  mismatches = mismatches + 1;
               end
               if (got.access_addr !== want.access_addr) begin
                  $display("%0t access_addr expected %h actual %h", $time,
                           want.access_addr, got.access_addr);
                  mismatches = mismatches + 1;
               end
            end
            words_checked = words_checked + 1;
         end
         if (req_chan.valid && req_chan.ready) begin
            ev.action            = req_chan.action;
            ev.data_byte         = req_chan.data_byte;
            ev.rendering_enabled = req_chan.rendering_enabled;
            ev.in_render_line    = req_chan.in_render_line;
            expected_regs.push_back(predict_scroll(ev));
            action_hits[ev.action] = action_hits[ev.action] + 1;
            events_taken = events_taken + 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int sel;
      int n;
      int codes_hit;
      req_chan.valid             = 1'b0;
      req_chan.action            = ACT_CTRL_WRITE;
      req_chan.data_byte         = 8'h00;
      req_chan.rendering_enabled = 1'b0;
      req_chan.in_render_line    = 1'b0;
      rsp_chan.ready             = 1'b0;
      for (int i = 0; i < 16; i++) action_hits[i] = 0;

      // directed: row 29 and 31 wrap, coarse X wrap, gated render events,
      // v wrap at 15 bits, toggle clear, both data access modes, unused codes
      queue_event(ACT_CTRL_WRITE,   8'hFF, 1'b0, 1'b0);
      queue_event(ACT_SCROLL_WRITE, 8'hFF, 1'b0, 1'b0);
      queue_event(ACT_SCROLL_WRITE, 8'hEF, 1'b0, 1'b0);
      queue_event(ACT_VCOPY,        8'h00, 1'b1, 1'b1);
      queue_event(ACT_HCOPY,        8'h00, 1'b1, 1'b1);
      queue_event(ACT_INC_X,        8'h00, 1'b1, 1'b1);
      queue_event(ACT_INC_Y,        8'h00, 1'b1, 1'b1);
      queue_event(ACT_INC_X,        8'hFF, 1'b0, 1'b1);
      queue_event(ACT_INC_Y,        8'hFF, 1'b0, 1'b1);
      queue_event(ACT_HCOPY,        8'hFF, 1'b0, 1'b1);
      queue_event(ACT_VCOPY,        8'hFF, 1'b0, 1'b1);
      queue_event(ACT_ADDR_WRITE,   8'hFF, 1'b0, 1'b0);
      queue_event(ACT_ADDR_WRITE,   8'hFF, 1'b0, 1'b0);
      queue_event(ACT_DATA_ACCESS,  8'h00, 1'b0, 1'b0);
      queue_event(ACT_ADDR_WRITE,   8'h00, 1'b0, 1'b0);
      queue_event(ACT_STATUS_READ,  8'h00, 1'b0, 1'b0);
      queue_event(ACT_CTRL_WRITE,   8'h03, 1'b0, 1'b0);
      queue_event(ACT_SCROLL_WRITE, 8'hFF, 1'b0, 1'b0);
      queue_event(ACT_SCROLL_WRITE, 8'hFF, 1'b0, 1'b0);
      queue_event(ACT_VCOPY,        8'h00, 1'b1, 1'b0);
      queue_event(ACT_HCOPY,        8'h00, 1'b1, 1'b0);
      queue_event(ACT_DATA_ACCESS,  8'h00, 1'b1, 1'b0);
      queue_event(ACT_VCOPY,        8'h00, 1'b1, 1'b0);
      queue_event(ACT_INC_Y,        8'h00, 1'b1, 1'b0);
      queue_event(ACT_DATA_ACCESS,  8'h00, 1'b1, 1'b1);
      queue_event(4'hF,             8'hFF, 1'b1, 1'b1);
      queue_event(4'h9,             8'h00, 1'b0, 1'b0);

      while (pending_events.size() < EventTarget) begin
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               queue_event(ACT_INC_X, 8'($urandom_range(0, 255)), rand_rend(), 1'b1);
            queue_event(ACT_INC_Y, 8'($urandom_range(0, 255)), rand_rend(), 1'b1);
            queue_event(ACT_HCOPY, 8'($urandom_range(0, 255)), rand_rend(), 1'b1);
            if ($urandom_range(0, 9) == 0)
               queue_event(ACT_VCOPY, 8'($urandom_range(0, 255)), rand_rend(), 1'b1);
         end else if (sel < 45) begin
            if ($urandom_range(0, 1))
               queue_event(ACT_STATUS_READ, 8'($urandom_range(0, 255)), rand_rend(),
                           1'($urandom_range(0, 1)));
            queue_event(ACT_SCROLL_WRITE, 8'($urandom_range(0, 255)), rand_rend(),
                        1'($urandom_range(0, 1)));
            queue_event(ACT_SCROLL_WRITE, 8'($urandom_range(0, 255)), rand_rend(),
                        1'($urandom_range(0, 1)));
         end else if (sel < 60) begin
            queue_event(ACT_ADDR_WRITE, 8'($urandom_range(0, 255)), rand_rend(),
                        1'($urandom_range(0, 1)));
            queue_event(ACT_ADDR_WRITE, 8'($urandom_range(0, 255)), rand_rend(),
                        1'($urandom_range(0, 1)));
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               queue_event(ACT_DATA_ACCESS, 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (sel < 68) begin
            queue_event(ACT_CTRL_WRITE, 8'($urandom_range(0, 255)), rand_rend(),
                        1'($urandom_range(0, 1)));
         end else if (sel < 95) begin
            queue_event(4'($urandom_range(0, 8)), 8'($urandom_range(0, 255)), rand_rend(),
                        1'($urandom_range(0, 1)));
         end else begin
            queue_event(4'($urandom_range(9, 15)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_events.size() > 0 || req_chan.valid || expected_regs.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (expected_regs.size() > 0) begin
         $display("%0t %0d expected words never arrived", $time, expected_regs.size());
         mismatches = mismatches + 1;
      end

      codes_hit = 0;
      for (int i = 0; i < 9; i++)
         if (action_hits[i] > 0) codes_hit = codes_hit + 1;
      $display("%0d events in, %0d words checked, %0d of 9 actions exercised",
               events_taken, words_checked, codes_hit);
      $display("random gaps on both sides plus one %0d-cycle response hold", HoldCycles);

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
